// ----- sv/gzs_pkg.sv -----
// Shared types and constants for the gzip header and trailer stripper.
// No dependencies; every other file of the block but gzs_if imports this package.
`timescale 1ns / 1ps

package gzs_pkg;

    // Default number of trailer bytes held back (CRC32 plus ISIZE)
    localparam int GZS_TRAILER_BYTES = 8;

    // Fixed header bytes and identification values
    localparam int         HDR_FIXED_LEN = 10;
    localparam logic [7:0] MAGIC_ID1     = 8'h1F;
    localparam logic [7:0] MAGIC_ID2     = 8'h8B;
    localparam logic [7:0] METHOD_DEFL   = 8'h08;

    // Position of each option in the latched flags (FLG bits 1..4 shifted down)
    localparam int OPT_HCRC_BIT    = 0;   // FLG 0x02
    localparam int OPT_EXTRA_BIT   = 1;   // FLG 0x04
    localparam int OPT_NAME_BIT    = 2;   // FLG 0x08
    localparam int OPT_COMMENT_BIT = 3;   // FLG 0x10

    // End-of-member status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_MAGIC  = 2'd1,
        ST_TRUNCATED  = 2'd2,
        ST_NO_PAYLOAD = 2'd3
    } t_status;

    // Parser view of the word being accepted
    typedef struct packed {
        logic payload;     // word belongs to the payload section
        logic bad;         // member is being discarded after a bad magic
        logic incomplete;  // header or an optional section is unfinished
    } t_prs_info;

endpackage

// ----- sv/gzs_if.sv -----
// Stream interfaces for the gzip header and trailer stripper.
// Depends on nothing; used by the top level and by the connecting logic.
`timescale 1ns / 1ps

interface gzs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gzs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       end_of_member;
    logic [1:0] status;

    modport source (output valid, output out_byte, output out_valid,
                    output end_of_member, output status, input ready);
    modport sink   (input valid, input out_byte, input out_valid,
                    input end_of_member, input status, output ready);
endinterface

// ----- sv/gzs_parser.sv -----
// Header section tracker: magic check, flag latch, optional section skipping.
// Depends on gzs_pkg for constants and the t_prs_info struct.
`timescale 1ns / 1ps

module gzs_parser
    import gzs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_prs_info  o_info
);

    typedef enum logic [2:0] {
        PH_FIXED   = 3'd0,
        PH_XLEN    = 3'd1,
        PH_XSKIP   = 3'd2,
        PH_NAME    = 3'd3,
        PH_COMMENT = 3'd4,
        PH_HCRC    = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_DISCARD = 3'd7
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [3:0]  r_flags, n_flags;
    logic [15:0] r_skip, n_skip;
    logic [7:0]  r_low, n_low;
    logic        r_bad, n_bad;
    logic [15:0] skip_dec;

    // Pick the first section at or after 'from' that the flags ask for
    function automatic t_phase enter_section(input t_phase from, input logic [3:0] flags);
        t_phase ph;
        ph = PH_PAYLOAD;
        if (from <= PH_HCRC && flags[OPT_HCRC_BIT])
            ph = PH_HCRC;
        if (from <= PH_COMMENT && flags[OPT_COMMENT_BIT])
            ph = PH_COMMENT;
        if (from <= PH_NAME && flags[OPT_NAME_BIT])
            ph = PH_NAME;
        if (from <= PH_XLEN && flags[OPT_EXTRA_BIT])
            ph = PH_XLEN;
        return ph;
    endfunction

    assign skip_dec = r_skip - {15'd0, (r_skip != 16'd0)};

    // Next state for the word at the input
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_flags = r_flags;
        n_skip  = r_skip;
        n_low   = r_low;
        n_bad   = r_bad;
        unique case (r_phase)
            PH_FIXED: begin
                if ((r_idx == 4'd0 && i_byte != MAGIC_ID1) ||
                    (r_idx == 4'd1 && i_byte != MAGIC_ID2) ||
                    (r_idx == 4'd2 && i_byte != METHOD_DEFL))
                    n_bad = 1'b1;
                if (r_idx == 4'd3)
                    n_flags = i_byte[4:1];
                if (r_idx >= 4'(HDR_FIXED_LEN - 1)) begin
                    n_idx = 4'd0;
                    if (n_bad)
                        n_phase = PH_DISCARD;
                    else
                        n_phase = enter_section(PH_XLEN, r_flags);
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            PH_XLEN: begin
                if (r_idx == 4'd0) begin
                    n_low = i_byte;
                    n_idx = 4'd1;
                end else begin
                    n_skip = {i_byte, r_low};
                    n_idx  = 4'd0;
                    if ({i_byte, r_low} == 16'd0)
                        n_phase = enter_section(PH_NAME, r_flags);
                    else
                        n_phase = PH_XSKIP;
                end
            end
            PH_XSKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_idx   = 4'd0;
                    n_phase = enter_section(PH_NAME, r_flags);
                end
            end
            PH_NAME: begin
                if (i_byte == 8'd0) begin
                    n_idx   = 4'd0;
                    n_phase = enter_section(PH_COMMENT, r_flags);
                end
            end
            PH_COMMENT: begin
                if (i_byte == 8'd0) begin
                    n_idx   = 4'd0;
                    n_phase = enter_section(PH_HCRC, r_flags);
                end
            end
            PH_HCRC: begin
                if (r_idx == 4'd0) begin
                    n_idx = 4'd1;
                end else begin
                    n_idx   = 4'd0;
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD, PH_DISCARD: begin
                n_phase = r_phase;
            end
            default: n_phase = r_phase;
        endcase
    end

    // Report the section of this word and where the member stands after it
    always_comb begin
        o_info.payload    = (r_phase == PH_PAYLOAD);
        o_info.bad        = (n_phase == PH_DISCARD);
        o_info.incomplete = (n_phase != PH_PAYLOAD) && (n_phase != PH_DISCARD);
    end

    // Hold state; drop back to the start after the last word of a member
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase <= PH_FIXED;
            r_idx   <= 4'd0;
            r_flags <= 4'd0;
            r_skip  <= 16'd0;
            r_low   <= 8'd0;
            r_bad   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_flags <= n_flags;
            r_skip  <= n_skip;
            r_low   <= n_low;
            r_bad   <= n_bad;
        end
    end

endmodule

// ----- sv/gzs_delay.sv -----
// Trailer delay line: holds back the last TRAILER_BYTES payload words.
// Depends on gzs_pkg for the default depth.
`timescale 1ns / 1ps

module gzs_delay
    import gzs_pkg::*;
#(
    parameter int TRAILER_BYTES = GZS_TRAILER_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_clear,
    input  logic [7:0] i_byte,
    output logic       o_pop,
    output logic [7:0] o_pop_byte
);

    localparam int IDX_W = (TRAILER_BYTES > 1) ? $clog2(TRAILER_BYTES) : 1;
    localparam int CNT_W = $clog2(TRAILER_BYTES + 1);

    logic [7:0]       r_delay [TRAILER_BYTES];
    logic [CNT_W-1:0] r_fill;
    logic             full;

    assign full       = (r_fill == CNT_W'(TRAILER_BYTES));
    assign o_pop      = i_push && full;
    assign o_pop_byte = r_delay[0];

    // Count held words; empty the line at the end of a member
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_fill <= '0;
        end else if (i_push && !full) begin
            r_fill <= r_fill + CNT_W'(1);
        end
    end

    // Fill in place until full, then shift the oldest word out
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (full) begin
                for (int i = 0; i < TRAILER_BYTES - 1; i++)
                    r_delay[i] <= r_delay[i + 1];
                r_delay[TRAILER_BYTES - 1] <= i_byte;
            end else begin
                r_delay[r_fill[IDX_W-1:0]] <= i_byte;
            end
        end
    end

endmodule

// ----- sv/gzip_header_stripper.sv -----
// Top level of the gzip member header and trailer stripper.
// Depends on gzs_pkg, gzs_if (gzs_in_if, gzs_out_if), gzs_parser and gzs_delay.
`timescale 1ns / 1ps

// Takes one gzip member a word (byte) at a time and passes only the deflate
// payload: the 10-byte fixed header, the optional extra field, name, comment
// and header CRC are removed, and the last TRAILER_BYTES words are held back
// and dropped as the trailer. One word is accepted every clock while the output
// register is empty or being taken; a result appears in the cycle after the
// word that causes it, in a single output register that is refilled in the
// same cycle it is taken. The word marked last always yields one result with
// end_of_member set and a status: ok, bad magic or method, truncated header
// (also when fewer than 10 words came), or no payload. After it the block is
// ready for the next member at once. Trailer CRC and size are not checked.
module gzip_header_stripper
    import gzs_pkg::*;
#(
    parameter int TRAILER_BYTES = GZS_TRAILER_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gzs_in_if.sink           i_in,
    gzs_out_if.source        o_out
);

    t_prs_info  prs_info;
    logic       accept;
    logic       pop;
    logic [7:0] pop_byte;
    logic       emit;
    t_status    n_status;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_oval;
    logic       r_end;
    t_status    r_status;

    // Take a word whenever the output register is empty or being drained
    assign i_in.ready = !r_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    gzs_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.data_byte),
        .i_last   (i_in.last_byte),
        .o_info   (prs_info)
    );

    gzs_delay #(
        .TRAILER_BYTES (TRAILER_BYTES)
    ) u_delay (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept && prs_info.payload),
        .i_clear    (accept && i_in.last_byte),
        .i_byte     (i_in.data_byte),
        .o_pop      (pop),
        .o_pop_byte (pop_byte)
    );

    assign emit = accept && (pop || i_in.last_byte);

    // Rank the end status: discard, then unfinished header, then empty payload
    always_comb begin
        priority if (!i_in.last_byte)
            n_status = ST_OK;
        else if (prs_info.bad)
            n_status = ST_BAD_MAGIC;
        else if (prs_info.incomplete)
            n_status = ST_TRUNCATED;
        else if (!pop)
            n_status = ST_NO_PAYLOAD;
        else
            n_status = ST_OK;
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte   <= pop ? pop_byte : 8'd0;
            r_oval   <= pop;
            r_end    <= i_in.last_byte;
            r_status <= n_status;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.out_byte      = r_byte;
    assign o_out.out_valid     = r_oval;
    assign o_out.end_of_member = r_end;
    assign o_out.status        = r_status;

    // A result without the end mark always carries a payload word
    a_mid_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_end |-> r_oval)
        else $error("non-final result without payload word");

    // Only the end result carries a status other than ok
    a_status_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_status != ST_OK) |-> r_end)
        else $error("status reported before end of member");

    // The last word of a member always produces an end result
    a_last_gives_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.last_byte |=> r_valid && r_end)
        else $error("last word did not produce an end result");

endmodule

// ----- bench/gzs_strip_checker.sv -----
// Checker for the gzip header and trailer stripper: models the header parser
// and the trailer delay, and compares every output word it sees.
// Depends on gzs_pkg and the stream interfaces in gzs_if.
`timescale 1ns / 1ps

module gzs_strip_checker
    import gzs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    gzs_in_if    i_in_ch,
    gzs_out_if   i_out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    // Sections of a member, in stream order
    typedef enum logic [2:0] {
        SEC_FIXED,
        SEC_XLEN,
        SEC_XSKIP,
        SEC_NAME,
        SEC_COMMENT,
        SEC_HCRC,
        SEC_PAYLOAD,
        SEC_DISCARD
    } t_section;

    // One output word as the block should present it
    typedef struct packed {
        logic [7:0] data;
        logic       data_vld;
        logic       eom;
        t_status    status;
    } t_strip_word;

    t_section    section;
    logic [3:0]  hdr_pos;
    logic [3:0]  opt_flags;
    logic [15:0] skip_left;
    logic [7:0]  xlen_lo;
    logic [7:0]  tail_buf [GZS_TRAILER_BYTES];
    int          tail_fill;
    logic        bad_magic;
    t_strip_word out_word_q[$];

    // Return the parser to the start of a member
    function automatic void clear_parser();
        section   = SEC_FIXED;
        hdr_pos   = '0;
        opt_flags = '0;
        skip_left = '0;
        xlen_lo   = '0;
        tail_fill = 0;
        bad_magic = 1'b0;
        for (int i = 0; i < GZS_TRAILER_BYTES; i++) tail_buf[i] = '0;
    endfunction

    // Move to the first section at or after 'from' that the flags select
    function automatic void enter_section(input t_section from);
        hdr_pos = '0;
        if (from <= SEC_XLEN && opt_flags[OPT_EXTRA_BIT]) section = SEC_XLEN;
        else if (from <= SEC_NAME && opt_flags[OPT_NAME_BIT]) section = SEC_NAME;
        else if (from <= SEC_COMMENT && opt_flags[OPT_COMMENT_BIT]) section = SEC_COMMENT;
        else if (from <= SEC_HCRC && opt_flags[OPT_HCRC_BIT]) section = SEC_HCRC;
        else section = SEC_PAYLOAD;
    endfunction

    // Advance the parser by one accepted word and queue what it yields
    function automatic void strip_byte(input logic [7:0] b, input logic last);
        logic        popped;
        logic [7:0]  pop_b;
        t_strip_word w;
        popped = 1'b0;
        pop_b  = '0;
        case (section)
            SEC_FIXED: begin
                if ((hdr_pos == 0 && b != MAGIC_ID1) || (hdr_pos == 1 && b != MAGIC_ID2) ||
                    (hdr_pos == 2 && b != METHOD_DEFL))
                    bad_magic = 1'b1;
                if (hdr_pos == 3) opt_flags = b[4:1];
                if (hdr_pos >= 4'(HDR_FIXED_LEN - 1)) begin
                    if (bad_magic) section = SEC_DISCARD;
                    else enter_section(SEC_XLEN);
                end else begin
                    hdr_pos++;
                end
            end
            SEC_XLEN: begin
                if (hdr_pos == 0) begin
                    xlen_lo = b;
                    hdr_pos = 1;
                end else begin
                    skip_left = {b, xlen_lo};
                    if (skip_left == 0) enter_section(SEC_NAME);
                    else section = SEC_XSKIP;
                end
            end
            SEC_XSKIP: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) enter_section(SEC_NAME);
            end
            SEC_NAME: begin
                if (b == 0) enter_section(SEC_COMMENT);
            end
            SEC_COMMENT: begin
                if (b == 0) enter_section(SEC_HCRC);
            end
            SEC_HCRC: begin
                if (hdr_pos == 0) hdr_pos = 1;
                else enter_section(SEC_PAYLOAD);
            end
            SEC_PAYLOAD: begin
                // Hold the newest trailer-sized window, release the oldest word
                if (tail_fill >= GZS_TRAILER_BYTES) begin
                    popped = 1'b1;
                    pop_b  = tail_buf[0];
                    for (int i = 0; i < GZS_TRAILER_BYTES - 1; i++) tail_buf[i] = tail_buf[i + 1];
                    tail_buf[GZS_TRAILER_BYTES - 1] = b;
                end else begin
                    tail_buf[tail_fill] = b;
                    tail_fill++;
                end
            end
            default: ;
        endcase

        if (popped || last) begin
            w.data     = popped ? pop_b : 8'h00;
            w.data_vld = popped;
            w.eom      = last;
            w.status   = ST_OK;
            if (last) begin
                if (section == SEC_DISCARD) w.status = ST_BAD_MAGIC;
                else if (section != SEC_PAYLOAD) w.status = ST_TRUNCATED;
                else if (!popped) w.status = ST_NO_PAYLOAD;
            end
            out_word_q.push_back(w);
        end
        if (last) clear_parser();
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    // Compare one output word with the oldest expected one
    function automatic void check_word(input t_strip_word act);
        t_strip_word exp_w;
        if (out_word_q.size() == 0) begin
            $display("%0t: unexpected output word, expected none, actual %h", $time, act);
            o_fail_count++;
        end else begin
            exp_w = out_word_q.pop_front();
            check_field("out_byte", exp_w.data, act.data);
            check_field("out_valid", 8'(exp_w.data_vld), 8'(act.data_vld));
            check_field("end_of_member", 8'(exp_w.eom), 8'(act.eom));
            check_field("status", 8'(exp_w.status), 8'(act.status));
        end
    endfunction

    // Watch both channels at each rising edge
    always @(posedge i_clk) begin : watch
        t_strip_word act;
        if (!i_rst_n) begin
            clear_parser();
            out_word_q.delete();
        end else begin
            if (i_in_ch.valid && i_in_ch.ready)
                strip_byte(i_in_ch.data_byte, i_in_ch.last_byte);
            if (i_out_ch.valid && i_out_ch.ready) begin
                act.data     = i_out_ch.out_byte;
                act.data_vld = i_out_ch.out_valid;
                act.eom      = i_out_ch.end_of_member;
                act.status   = t_status'(i_out_ch.status);
                check_word(act);
                o_checked++;
            end
        end
        o_pending = out_word_q.size();
    end

endmodule

// ----- bench/gzip_header_stripper_tb.sv -----
// Testbench top for the gzip header and trailer stripper: builds gzip members
// (well-formed, cut short, corrupted, noise), drives them with random stalls.
// Depends on gzs_pkg, gzs_if, gzip_header_stripper and gzs_strip_checker.
`timescale 1ns / 1ps

module gzip_header_stripper_tb;
    import gzs_pkg::*;

    localparam int ITEM_TARGET = 1350;
    localparam int QUIET_FROM  = 1200;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gzs_in_if  in_ch ();
    gzs_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;

    gzip_header_stripper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gzs_strip_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    logic [7:0] member_q[$];
    int         bytes_sent;
    int         members_sent;
    bit         hold_req;
    bit         quiet;
    int         cycle_cnt;

    // Clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Count cycles and end the run on a hang
    always @(posedge i_clk) cycle_cnt++;

    initial begin : watchdog
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d words still expected", $time, pending);
        $display("TB_ERROR");
        $finish;
    end

    // Output side: random back-pressure, one long hold on request
    initial begin : receiver
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (quiet || $urandom_range(0, 5) != 0) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge i_clk);
            end
        end
    end

    // Offer one word and hold it until accepted; returns at a falling edge
    task automatic send_word(input logic [7:0] d, input logic l);
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.last_byte <= l;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid for a hold whose length is set by n
    task automatic hold_sender(input int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_results_done();
        while (pending != 0) @(negedge i_clk);
    endtask

    // Shorten the member to n words
    task automatic cut_member(input int n);
        while (member_q.size() > n) void'(member_q.pop_back());
    endtask

    // Assemble a well-formed member; body_len counts payload plus trailer words
    task automatic build_member(input logic [7:0] flg, input int xlen, input int name_len,
                                input int cmt_len, input int body_len);
        member_q.delete();
        member_q.push_back(MAGIC_ID1);
        member_q.push_back(MAGIC_ID2);
        member_q.push_back(METHOD_DEFL);
        member_q.push_back(flg);
        repeat (HDR_FIXED_LEN - 4) member_q.push_back(8'($urandom));
        if (flg[OPT_EXTRA_BIT + 1]) begin
            member_q.push_back(xlen[7:0]);
            member_q.push_back(xlen[15:8]);
            repeat (xlen) member_q.push_back(8'($urandom));
        end
        if (flg[OPT_NAME_BIT + 1]) begin
            repeat (name_len) member_q.push_back(8'($urandom_range(1, 255)));
            member_q.push_back(8'h00);
        end
        if (flg[OPT_COMMENT_BIT + 1]) begin
            repeat (cmt_len) member_q.push_back(8'($urandom_range(1, 255)));
            member_q.push_back(8'h00);
        end
        if (flg[OPT_HCRC_BIT + 1]) repeat (2) member_q.push_back(8'($urandom));
        repeat (body_len) member_q.push_back(8'($urandom));
    endtask

    // Send the built member, the final word marked last
    task automatic send_member();
        bit calm;
        calm = ($urandom_range(0, 3) == 0);
        foreach (member_q[i]) begin
            send_word(member_q[i], i == member_q.size() - 1);
            if (!quiet && !calm && $urandom_range(0, 7) == 0) hold_sender($urandom_range(1, 14));
        end
        members_sent++;
    endtask

    initial begin : stimulus
        int kind;
        int k;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.last_byte <= 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Plain member, three payload words out
        build_member(8'h00, 0, 0, 0, 11);
        send_member();
        // All optional sections present
        build_member(8'h1E, 3, 2, 1, 9);
        send_member();
        // Extra field of length zero
        build_member(8'h04, 0, 0, 0, 12);
        send_member();
        // Payload no longer than the trailer, then header alone
        build_member(8'h00, 0, 0, 0, 8);
        send_member();
        build_member(8'h00, 0, 0, 0, 0);
        send_member();
        // Bad first magic byte, then bad method with exactly ten words
        build_member(8'h00, 0, 0, 0, 5);
        member_q[0] = 8'h1E;
        send_member();
        build_member(8'h00, 0, 0, 0, 0);
        member_q[2] = 8'h07;
        send_member();
        // Bad magic but fewer than ten words: truncation wins
        build_member(8'h00, 0, 0, 0, 0);
        member_q[1] = 8'h00;
        cut_member(9);
        send_member();
        // Single-word member
        member_q.delete();
        member_q.push_back(MAGIC_ID1);
        send_member();
        // Name never terminated
        build_member(8'h08, 0, 3, 0, 10);
        cut_member(12);
        send_member();
        // Text and reserved flag bits only
        build_member(8'hE1, 0, 0, 0, 10);
        send_member();
        // Largest extra length, cut long before its end
        build_member(8'h04, 0, 0, 0, 6);
        member_q[10] = 8'hFF;
        member_q[11] = 8'hFF;
        send_member();
        // Header CRC cut after one word
        build_member(8'h02, 0, 0, 0, 0);
        cut_member(11);
        send_member();
        hold_sender(1);
        wait_results_done();

        // Random members until the word budget is spent
        while (bytes_sent < ITEM_TARGET) begin
            if (bytes_sent >= QUIET_FROM) quiet = 1'b1;
            if (members_sent == 20) hold_req = 1'b1;
            if (members_sent == 45) begin
                hold_sender(1);
                wait_results_done();
            end
            build_member(8'($urandom),
                         ($urandom_range(0, 39) == 0) ? $urandom_range(200, 300)
                                                       : $urandom_range(0, 6),
                         $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 24));
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // Noise, sometimes with a plausible first word
                member_q.delete();
                repeat ($urandom_range(1, 20)) member_q.push_back(8'($urandom));
                if ($urandom_range(0, 1) == 1) member_q[0] = MAGIC_ID1;
            end else if (kind == 1) begin
                cut_member($urandom_range(1, member_q.size()));
            end else if (kind == 2) begin
                k = $urandom_range(0, 2);
                member_q[k] = member_q[k] ^ 8'($urandom_range(1, 255));
            end
            send_member();
        end

        // Drain and let any stray word show up
        hold_sender(1);
        wait_results_done();
        repeat (20) @(negedge i_clk);

        $display("Sent %0d members (%0d words): clean, corrupted, cut short and noise.",
                 members_sent, bytes_sent);
        $display("Compared %0d output words, %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- gzip_header_stripper.f -----
sv/gzs_pkg.sv
sv/gzs_if.sv
sv/gzs_parser.sv
sv/gzs_delay.sv
sv/gzip_header_stripper.sv
bench/gzs_strip_checker.sv
bench/gzip_header_stripper_tb.sv
